/* sv/pge_pkg.sv */
package pge_pkg;

    // Sizing
    localparam int MAX_ELEMENTS = 64;
    localparam int FRAC_BITS    = 16;
    localparam int PROB_W       = 17;
    localparam int OUT_W        = 23;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int RANK_PROD_W  = CNT_W + PROB_W;
    // sum of ranks 1..MAX times the largest element
    localparam int ACC_W        = PROB_W + $clog2(MAX_ELEMENTS * (MAX_ELEMENTS + 1) / 2 + 1);
    localparam int PROD_W       = ACC_W + PROB_W;
    localparam int WGT_W        = PROD_W - FRAC_BITS;

    // Saturation cap of the running total
    localparam longint unsigned CAP_FULL = longint'(MAX_ELEMENTS) << FRAC_BITS;
    localparam longint unsigned OUT_MAX  = (longint'(1) << OUT_W) - 1;
    localparam logic [OUT_W-1:0] TOTAL_CAP =
        (CAP_FULL > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(CAP_FULL);

    // Controller to datapath
    typedef struct packed {
        logic accept;     // take the input item
        logic shift;      // one insertion step
        logic sum_start;  // clear accumulator, read first entry
        logic sum_step;   // accumulate one ranked entry
        logic mul;        // column sum times column weight
        logic add;        // saturating add into total
        logic emit;       // load output register, clear totals
    } pge_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;        // store holds MAX_ELEMENTS
        logic empty;       // store holds nothing
        logic shift_done;  // insertion slot found
        logic sum_last;    // current entry is the last stored one
        logic close;       // latched item closes its column
        logic fin;         // latched item is the final one
    } pge_stat_t;

endpackage

/* sv/pge_datapath.sv */
module pge_datapath
    import pge_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  pge_cmd_t          cmd,
    output pge_stat_t         stat,
    input  logic [PROB_W-1:0] s_probability,
    input  logic [PROB_W-1:0] s_column_weight,
    input  logic              s_column_end,
    input  logic              s_final_item,
    output logic [OUT_W-1:0]  m_entropy_value,
    output logic              m_error_flag
);

    logic [PROB_W-1:0] store_mem [MAX_ELEMENTS];

    logic [PROB_W-1:0] prob_reg;
    logic [PROB_W-1:0] weight_reg;
    logic              close_reg;
    logic              fin_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [PROB_W-1:0] rd_data_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [OUT_W-1:0]  total_reg;
    logic              ovf_reg;
    logic [OUT_W-1:0]  out_value_reg;
    logic              out_error_reg;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [PROB_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
    logic              moving;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  rank;
    logic [RANK_PROD_W-1:0] rank_prod;
    logic [WGT_W-1:0]  weighted;
    logic [WGT_W:0]    total_sum;
    logic              saturate;

    assign full   = (count_reg == CNT_W'(MAX_ELEMENTS));
    assign empty  = (count_reg == '0);
    // entry above the hole is smaller than the new value: move it down
    assign moving = (idx_reg != '0) && (rd_data_reg < prob_reg);

    assign rank      = {1'b0, idx_reg} + CNT_W'(1);
    assign rank_prod = rank * rd_data_reg;

    assign weighted  = prod_reg[PROD_W-1:FRAC_BITS];
    assign total_sum = {{(WGT_W+1-OUT_W){1'b0}}, total_reg} + {1'b0, weighted};
    assign saturate  = (weighted >= WGT_W'(TOTAL_CAP))
                    || (total_sum > (WGT_W+1)'(TOTAL_CAP));

    assign stat.full       = full;
    assign stat.empty      = empty;
    assign stat.shift_done = !moving;
    assign stat.sum_last   = (rank == count_reg);
    assign stat.close      = close_reg;
    assign stat.fin        = fin_reg;

    // Store write port
    always_comb begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = prob_reg;
        if (cmd.accept && empty) begin
            we    = 1'b1;
            waddr = '0;
            wdata = s_probability;
        end else if (cmd.shift) begin
            we    = 1'b1;
            wdata = moving ? rd_data_reg : prob_reg;
        end
    end

    // Store read address
    always_comb begin
        raddr = idx_reg;
        if (cmd.accept) begin
            raddr = IDX_W'(count_reg - CNT_W'(1));
        end else if (cmd.shift) begin
            raddr = idx_reg - IDX_W'(2);
        end else if (cmd.sum_start) begin
            raddr = '0;
        end else if (cmd.sum_step) begin
            raddr = idx_reg + IDX_W'(1);
        end
    end

    // Column store, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
        rd_data_reg <= store_mem[raddr];
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            prob_reg   <= s_probability;
            weight_reg <= s_column_weight;
            close_reg  <= s_column_end | s_final_item;
            fin_reg    <= s_final_item;
            idx_reg    <= count_reg[IDX_W-1:0];
        end else if (cmd.shift) begin
            if (moving) begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end else if (cmd.sum_start) begin
            idx_reg <= '0;
            acc_reg <= '0;
        end else if (cmd.sum_step) begin
            idx_reg <= idx_reg + IDX_W'(1);
            acc_reg <= acc_reg + ACC_W'(rank_prod);
        end
        if (cmd.mul) begin
            prod_reg <= acc_reg * weight_reg;
        end
        if (cmd.emit) begin
            out_value_reg <= total_reg;
            out_error_reg <= ovf_reg;
        end
    end

    // Count, total and sticky error
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cmd.accept) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.add) begin
                count_reg <= '0;
                if (saturate) begin
                    total_reg <= TOTAL_CAP;
                    ovf_reg   <= 1'b1;
                end else begin
                    total_reg <= total_sum[OUT_W-1:0];
                end
            end
            if (cmd.emit) begin
                count_reg <= '0;
                total_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    assign m_entropy_value = out_value_reg;
    assign m_error_flag    = out_error_reg;

endmodule

/* sv/pge_ctrl.sv */
module pge_ctrl
    import pge_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_column_end,
    input  logic      s_final_item,
    output logic      m_valid,
    input  logic      m_ready,
    input  pge_stat_t stat,
    output pge_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SHIFT     = 3'd1;
    localparam logic [2:0] ST_SUM_START = 3'd2;
    localparam logic [2:0] ST_SUM       = 3'd3;
    localparam logic [2:0] ST_MUL       = 3'd4;
    localparam logic [2:0] ST_ADD       = 3'd5;
    localparam logic [2:0] ST_OUT       = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (!stat.full && !stat.empty) begin
                        state_next = ST_SHIFT;
                    end else if (s_column_end || s_final_item) begin
                        state_next = ST_SUM_START;
                    end
                end
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (stat.shift_done) begin
                    state_next = stat.close ? ST_SUM_START : ST_IDLE;
                end
            end
            ST_SUM_START: begin
                cmd.sum_start = 1'b1;
                state_next    = stat.empty ? ST_MUL : ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (stat.sum_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = stat.fin ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on emit, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* sv/posterior_guessing_entropy_top.sv */
// Posterior guessing entropy. Items carry one Q1.16 probability each, column
// by column, with the column's outer weight; the weight on the closing item is
// the one used. Each arriving element is insertion-sorted into the column
// store (descending), which has one write and one read port, moving one store
// entry per cycle. An item that lands in an empty or a full store is taken
// with no shift step; otherwise it takes one shift step per stored element
// smaller than it plus a step that writes it into its slot.
// An item that closes a column then runs a start step, one rank-weighted
// multiply-accumulate per stored entry, the weight multiply and the
// saturating add. After the add, the final item loads the output register,
// waiting only if the previous result has not been taken. Elements past
// MAX_ELEMENTS are dropped and flag an error; the total saturates at
// MAX_ELEMENTS x 1.0 (or the 23-bit limit) and also flags an error.
module posterior_guessing_entropy_top
    import pge_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [PROB_W-1:0] s_probability,
    input  logic [PROB_W-1:0] s_column_weight,
    input  logic              s_column_end,
    input  logic              s_final_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [OUT_W-1:0]  m_entropy_value,
    output logic              m_error_flag
);

    pge_cmd_t  cmd;
    pge_stat_t stat;

    pge_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_column_end (s_column_end),
        .s_final_item (s_final_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    pge_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_probability   (s_probability),
        .s_column_weight (s_column_weight),
        .s_column_end    (s_column_end),
        .s_final_item    (s_final_item),
        .m_entropy_value (m_entropy_value),
        .m_error_flag    (m_error_flag)
    );

    // At most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.shift, cmd.sum_start, cmd.sum_step,
                  cmd.mul, cmd.add, cmd.emit}))
        else $error("multiple datapath commands");

    // Never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready))
        else $error("result overwritten");

    // A fresh result appears the cycle after an emit
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid)
        else $error("emit lost");

    // Result never exceeds the saturation cap
    a_result_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entropy_value <= TOTAL_CAP))
        else $error("result above cap");

endmodule

/* sim/pge_entropy_checker.sv */
// Watches both channels of the guessing entropy block, keeps its own model of
// the open column and the running total, and compares every result item.
module pge_entropy_checker
    import pge_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [PROB_W-1:0] s_probability,
    input  logic [PROB_W-1:0] s_column_weight,
    input  logic              s_column_end,
    input  logic              s_final_item,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [OUT_W-1:0]  m_entropy_value,
    input  logic              m_error_flag,
    output int                fail_count,
    output int                results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned FULL_SCALE = longint'(MAX_ELEMENTS) << FRAC_BITS;
    localparam longint unsigned OUT_LIMIT  = (longint'(1) << OUT_W) - 1;
    localparam longint unsigned SAT_LIMIT  =
        (FULL_SCALE > OUT_LIMIT) ? OUT_LIMIT : FULL_SCALE;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             overflow;
    } entropy_t;

    // model state
    logic [PROB_W-1:0] column_elems [MAX_ELEMENTS];
    int                held;
    longint unsigned   total_acc;
    logic              sticky_err;
    entropy_t          entropy_due [$];

    initial begin
        fail_count   = 0;
        results_owed = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t ns  entropy check: %s", $time, msg);
    endtask

    task automatic clear_model();
        held       = 0;
        total_acc  = 0;
        sticky_err = 1'b0;
    endtask

    // Descending insertion order, then sum of rank times value
    function automatic longint unsigned ranked_sum();
        logic [PROB_W-1:0] order [MAX_ELEMENTS];
        logic [PROB_W-1:0] v;
        longint unsigned   acc;
        int                j;
        acc = 0;
        for (int i = 0; i < held; i++) begin
            v = column_elems[i];
            j = i;
            while (j > 0 && order[j-1] < v) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
        end
        for (int i = 0; i < held; i++)
            acc += longint'(i + 1) * longint'(order[i]);
        return acc;
    endfunction

    // One accepted input item through the model
    task automatic absorb_item(input logic [PROB_W-1:0] prob, input logic [PROB_W-1:0] wgt,
                               input logic col_end, input logic fin);
        longint unsigned weighted;
        entropy_t        res;
        if (held < MAX_ELEMENTS) begin
            column_elems[held] = prob;
            held++;
        end else begin
            sticky_err = 1'b1;
        end
        // a final item closes the column even without its end mark
        if (col_end || fin) begin
            weighted = (ranked_sum() * longint'(wgt)) >> FRAC_BITS;
            if (weighted >= SAT_LIMIT || total_acc + weighted > SAT_LIMIT) begin
                total_acc  = SAT_LIMIT;
                sticky_err = 1'b1;
            end else begin
                total_acc += weighted;
            end
            held = 0;
        end
        if (fin) begin
            res.value    = OUT_W'(total_acc);
            res.overflow = sticky_err;
            entropy_due  = {entropy_due, res};
            clear_model();
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge aclk) begin
        entropy_t want;
        if (!aresetn) begin
            clear_model();
            entropy_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (entropy_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result item value=%0d flag=%b",
                                              m_entropy_value, m_error_flag));
                end else begin
                    want = entropy_due.pop_front();
                    if (m_entropy_value !== want.value)
                        report_mismatch($sformatf("entropy_value got %0d want %0d",
                                                  m_entropy_value, want.value));
                    if (m_error_flag !== want.overflow)
                        report_mismatch($sformatf("error_flag got %b want %b",
                                                  m_error_flag, want.overflow));
                end
            end
            if (s_valid && s_ready)
                absorb_item(s_probability, s_column_weight, s_column_end, s_final_item);
        end
        results_owed <= entropy_due.size();
    end

endmodule

/* sim/posterior_guessing_entropy_top_tb.sv */
module posterior_guessing_entropy_top_tb
    import pge_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                RAND_ITEMS     = 700;
    localparam int                QUIET_TAIL     = 120;
    localparam int                RX_HOLD_CYCLES = 300;
    localparam int                DRAIN_CYCLES   = 200;
    localparam logic [PROB_W-1:0] P_ONE          = PROB_W'(65536);
    localparam logic [PROB_W-1:0] P_FULL         = '1;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [PROB_W-1:0] s_probability;
    logic [PROB_W-1:0] s_column_weight;
    logic              s_column_end;
    logic              s_final_item;
    logic              m_valid;
    logic              m_ready;
    logic [OUT_W-1:0]  m_entropy_value;
    logic              m_error_flag;

    int fail_count;
    int results_owed;
    int items_sent;
    int hold_requests;
    bit quiet;

    posterior_guessing_entropy_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_probability   (s_probability),
        .s_column_weight (s_column_weight),
        .s_column_end    (s_column_end),
        .s_final_item    (s_final_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_entropy_value (m_entropy_value),
        .m_error_flag    (m_error_flag)
    );

    pge_entropy_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_probability   (s_probability),
        .s_column_weight (s_column_weight),
        .s_column_end    (s_column_end),
        .s_final_item    (s_final_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_entropy_value (m_entropy_value),
        .m_error_flag    (m_error_flag),
        .fail_count      (fail_count),
        .results_owed    (results_owed)
    );

    // 100 MHz clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    initial begin : watchdog
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random short stalls, plus one long hold on request
    initial begin : receiver
        int stall_left;
        int hold_served;
        stall_left  = 0;
        hold_served = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                stall_left  = RX_HOLD_CYCLES;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Mix of uniform, full-width, tiny (many ties) and corner values
    function automatic logic [PROB_W-1:0] rand_prob();
        case ($urandom_range(0, 5))
            0, 1:    return PROB_W'($urandom_range(0, 65536));
            2:       return PROB_W'($urandom_range(0, 131071));
            3:       return PROB_W'($urandom_range(0, 15));
            4:       return PROB_W'($urandom_range(0, 4096));
            default: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return P_ONE;
                    2:       return P_FULL;
                    default: return PROB_W'(32768);
                endcase
            end
        endcase
    endfunction

    function automatic logic [PROB_W-1:0] rand_weight();
        case ($urandom_range(0, 5))
            0:       return P_ONE;
            1:       return PROB_W'($urandom_range(0, 131071));
            2:       return '0;
            default: return PROB_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(input logic [PROB_W-1:0] prob, input logic [PROB_W-1:0] wgt,
                             input logic col_end, input logic fin);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_probability   <= prob;
        s_column_weight <= wgt;
        s_column_end    <= col_end;
        s_final_item    <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Stop offering until every result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    // A few columns ending in a final item; now and then a column past capacity
    task automatic send_sequence();
        int                ncols;
        int                len;
        logic [PROB_W-1:0] wgt;
        logic              last_col;
        ncols = $urandom_range(1, 4);
        for (int c = 0; c < ncols; c++) begin
            len      = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(1, 6);
            wgt      = rand_weight();
            last_col = (c == ncols - 1);
            for (int e = 0; e < len - 1; e++)
                send_item(rand_prob(), $urandom_range(0, 1) ? wgt : rand_weight(),
                          1'b0, 1'b0);
            if (last_col)
                send_item(rand_prob(), wgt, 1'($urandom_range(0, 1)), 1'b1);
            else
                send_item(rand_prob(), wgt, 1'b1, 1'b0);
        end
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        bit pressured;
        pressured       = 0;
        items_sent      = 0;
        quiet           = 0;
        hold_requests   = 0;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_probability   <= '0;
        s_column_weight <= '0;
        s_column_end    <= 1'b0;
        s_final_item    <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // plain prior: one column of weight 1.0
        send_item(PROB_W'(32768), P_ONE, 1'b0, 1'b0);
        send_item(PROB_W'(16384), P_ONE, 1'b0, 1'b0);
        send_item(PROB_W'(16384), P_ONE, 1'b1, 1'b1);

        // field extremes; last item is final without a column end
        send_item('0, '0, 1'b0, 1'b0);
        send_item(P_FULL, P_FULL, 1'b1, 1'b0);
        send_item(P_ONE, '0, 1'b1, 1'b0);
        send_item(P_FULL, P_ONE, 1'b0, 1'b1);

        // saturation of the total
        for (int i = 0; i < 7; i++)
            send_item(P_FULL, P_FULL, 1'b0, 1'b0);
        send_item(P_FULL, P_FULL, 1'b1, 1'b1);

        // column overflow: elements past capacity dropped, marks still honored
        for (int i = 0; i < MAX_ELEMENTS + 1; i++)
            send_item(PROB_W'($urandom_range(0, 2048)), P_ONE, 1'b0, 1'b0);
        send_item(PROB_W'(1024), P_ONE, 1'b1, 1'b0);
        send_item(PROB_W'(512), P_ONE, 1'b1, 1'b1);

        // random sequences
        while (items_sent < RAND_ITEMS) begin
            if (!pressured && items_sent >= RAND_ITEMS / 2) begin
                // drain fully, then hold the result side while results pile up
                pressured = 1;
                wait_drained();
                hold_requests <= hold_requests + 1;
                for (int k = 0; k < 6; k++) begin
                    send_item(rand_prob(), P_ONE, 1'b1, 1'b0);
                    send_item(rand_prob(), rand_weight(), 1'b1, 1'b1);
                end
            end
            if (items_sent >= RAND_ITEMS - QUIET_TAIL)
                quiet <= 1'b1;
            send_sequence();
        end

        // drain and settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && results_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
